[rtl/core/shp_pkg.sv]
package shp_pkg;

	localparam int CFG_AW = 5;
	localparam int DATA_W = 32;
	localparam int VAL_W  = 33;
	localparam int HB_W   = 10;

	localparam logic [2:0] REG_SEP_PLANES = 3'd0;
	localparam logic [2:0] REG_FRAME_NUM_W = 3'd1;
	localparam logic [2:0] REG_MBS_ONLY = 3'd2;
	localparam logic [2:0] REG_POC_TYPE = 3'd3;
	localparam logic [2:0] REG_POC_LSB_W = 3'd4;
	localparam logic [2:0] REG_BOTTOM_POC = 3'd5;

	localparam logic [4:0] WIDTH_MIN = 5'd4;
	localparam logic [4:0] WIDTH_MAX = 5'd16;

	typedef enum logic [3:0] {
		EL_FIRST_MB      = 4'd0,
		EL_SLICE_TYPE    = 4'd1,
		EL_PPS_ID        = 4'd2,
		EL_COLOUR_PLANE  = 4'd3,
		EL_FRAME_NUM     = 4'd4,
		EL_FIELD_PIC     = 4'd5,
		EL_BOTTOM_FIELD  = 4'd6,
		EL_IDR_PIC_ID    = 4'd7,
		EL_POC_LSB       = 4'd8,
		EL_DELTA_POC_BOT = 4'd9,
		EL_NO_OUTPUT     = 4'd10,
		EL_LONG_TERM     = 4'd11,
		EL_QP_DELTA      = 4'd12,
		EL_DONE          = 4'd13
	} elem_t;

	typedef enum logic [1:0] {
		KIND_UE  = 2'd0,
		KIND_SE  = 2'd1,
		KIND_FIX = 2'd2
	} kind_t;

	typedef enum logic {
		ENG_IDLE = 1'b0,
		ENG_RUN  = 1'b1
	} eng_state_t;

	typedef struct packed {
		logic       sep_planes;
		logic [4:0] frame_num_w;
		logic       mbs_only;
		logic [1:0] poc_type;
		logic [4:0] poc_lsb_w;
		logic       bottom_poc;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       idr;
	} in_word_t;

	typedef struct packed {
		logic [3:0]              element;
		logic signed [VAL_W-1:0] value;
		logic                    last;
		logic [HB_W-1:0]         hdr_bits;
		logic                    err;
	} result_t;

	function automatic logic [4:0] clamp_width(input logic [4:0] w);
		logic [4:0] r;
		r = w;
		if (w < WIDTH_MIN) r = WIDTH_MIN;
		else if (w > WIDTH_MAX) r = WIDTH_MAX;
		return r;
	endfunction

	function automatic kind_t kind_of(input elem_t code);
		kind_t k;
		case (code) inside
			EL_DELTA_POC_BOT, EL_QP_DELTA: k = KIND_SE;
			EL_FIRST_MB, EL_SLICE_TYPE, EL_PPS_ID, EL_IDR_PIC_ID: k = KIND_UE;
			default: k = KIND_FIX;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] fixed_width(input elem_t code, input cfg_t cfg);
		logic [4:0] w;
		case (code)
			EL_COLOUR_PLANE: w = 5'd2;
			EL_FRAME_NUM:    w = cfg.frame_num_w;
			EL_POC_LSB:      w = cfg.poc_lsb_w;
			default:         w = 5'd1;
		endcase
		return w;
	endfunction

	function automatic elem_t next_code(input elem_t code, input logic vbit, input cfg_t cfg,
	                                    input logic field, input logic idr);
		elem_t after_poc, after_idr, after_field, n;
		after_poc   = idr ? EL_NO_OUTPUT : EL_QP_DELTA;
		after_idr   = (cfg.poc_type == 2'd0) ? EL_POC_LSB : after_poc;
		after_field = idr ? EL_IDR_PIC_ID : after_idr;
		case (code)
			EL_FIRST_MB:      n = EL_SLICE_TYPE;
			EL_SLICE_TYPE:    n = EL_PPS_ID;
			EL_PPS_ID:        n = cfg.sep_planes ? EL_COLOUR_PLANE : EL_FRAME_NUM;
			EL_COLOUR_PLANE:  n = EL_FRAME_NUM;
			EL_FRAME_NUM:     n = cfg.mbs_only ? after_field : EL_FIELD_PIC;
			EL_FIELD_PIC:     n = vbit ? EL_BOTTOM_FIELD : after_field;
			EL_BOTTOM_FIELD:  n = after_field;
			EL_IDR_PIC_ID:    n = after_idr;
			EL_POC_LSB:       n = (!field && cfg.bottom_poc) ? EL_DELTA_POC_BOT : after_poc;
			EL_DELTA_POC_BOT: n = after_poc;
			EL_NO_OUTPUT:     n = EL_LONG_TERM;
			EL_LONG_TERM:     n = EL_QP_DELTA;
			default:          n = EL_DONE;
		endcase
		return n;
	endfunction

	// residue mod 5 after appending one bit
	function automatic logic [2:0] mod5_shift(input logic [2:0] m, input logic b);
		logic [3:0] t;
		t = {m, b};
		if (t >= 4'd5) t = t - 4'd5;
		return t[2:0];
	endfunction

endpackage

[rtl/core/shp_front.sv]
module shp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  shp_pkg::in_word_t in_word,
	output logic              q_valid,
	output shp_pkg::in_word_t q_word,
	input  logic              q_pop
);

	shp_pkg::in_word_t mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_word   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !q_pop) cnt_q <= cnt_q + 2'd1;
			else if (!push && q_pop) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

[rtl/core/shp_out_buf.sv]
module shp_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  shp_pkg::result_t push_res,
	output logic             space,
	output logic             out_valid,
	input  logic             out_ready,
	output shp_pkg::result_t out_res
);

	shp_pkg::result_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign space     = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_res   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (!push && pop) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

[rtl/core/shp_engine.sv]
module shp_engine #(
	parameter int MAX_HEADER_BITS = 1023
) (
	input  logic              clk,
	input  logic              arst_n,
	input  shp_pkg::cfg_t     cfg,
	input  logic              q_valid,
	input  shp_pkg::in_word_t q_word,
	output logic              q_pop,
	input  logic              space,
	output logic              push,
	output shp_pkg::result_t  res
);

	localparam int TW = $clog2(MAX_HEADER_BITS + 1);
	localparam int HW = (TW > shp_pkg::HB_W) ? TW : shp_pkg::HB_W;
	localparam int VW = shp_pkg::VAL_W;

	shp_pkg::eng_state_t state_q, state_nx;
	logic [7:0]          byte_q;
	logic                first_q;
	logic                byte_idr_q;
	logic [2:0]          bit_idx_q;

	shp_pkg::elem_t phase_q, phase_nx, eff_phase, nxt;
	logic [5:0]     zc_q, zc_nx, eff_zc;
	logic [VW-1:0]  acc_q, acc_nx, eff_acc;
	logic [5:0]     left_q, left_nx, eff_left;
	logic [2:0]     m_q, m_nx, eff_m;
	logic [TW-1:0]  total_q, total_nx, eff_total;
	logic           field_q, field_nx, eff_field;
	logic           idr_q, eff_idr;
	logic           done_q, done_nx, eff_done;

	shp_pkg::kind_t kind;
	logic           run, bit_in, step, complete, err, fin;
	logic [HW-1:0]  tot_ext;
	logic [VW-1:0]  half, v;

	assign run       = (state_q == shp_pkg::ENG_RUN);
	assign eff_done  = first_q ? 1'b0 : done_q;
	assign eff_phase = first_q ? shp_pkg::EL_FIRST_MB : phase_q;
	assign eff_zc    = first_q ? 6'd0 : zc_q;
	assign eff_acc   = first_q ? '0 : acc_q;
	assign eff_left  = first_q ? 6'd0 : left_q;
	assign eff_m     = first_q ? 3'd0 : m_q;
	assign eff_total = first_q ? '0 : total_q;
	assign eff_field = first_q ? 1'b0 : field_q;
	assign eff_idr   = first_q ? byte_idr_q : idr_q;

	assign bit_in = byte_q[bit_idx_q];
	assign kind   = shp_pkg::kind_of(eff_phase);
	assign step   = run && !eff_done && space;

	always_comb begin
		zc_nx    = eff_zc;
		acc_nx   = eff_acc;
		left_nx  = eff_left;
		m_nx     = eff_m;
		field_nx = eff_field;
		phase_nx = eff_phase;
		done_nx  = eff_done;
		complete = 1'b0;
		err      = 1'b0;
		total_nx = (eff_total < TW'(MAX_HEADER_BITS)) ? eff_total + 1'b1 : eff_total;

		if (kind == shp_pkg::KIND_FIX || eff_left != 6'd0) begin
			acc_nx   = {eff_acc[VW-2:0], bit_in};
			m_nx     = shp_pkg::mod5_shift(eff_m, bit_in);
			left_nx  = (eff_left != 6'd0) ? eff_left - 6'd1 : eff_left;
			complete = (left_nx == 6'd0);
		end else if (!bit_in) begin
			zc_nx = eff_zc + 6'd1;
			err   = (eff_zc == 6'd31);
		end else begin
			// prefix ends: acc holds codeNum+1 once the suffix is in
			acc_nx   = VW'(1);
			m_nx     = 3'd1;
			left_nx  = eff_zc;
			complete = (eff_zc == 6'd0);
		end

		half = {1'b0, acc_nx[VW-1:1]};
		case (kind)
			shp_pkg::KIND_UE: v = acc_nx - VW'(1);
			shp_pkg::KIND_SE: v = acc_nx[0] ? VW'(0) - half : half;
			default:          v = acc_nx;
		endcase
		if (eff_phase == shp_pkg::EL_SLICE_TYPE)
			v = (m_nx == 3'd0) ? VW'(4) : VW'(m_nx - 3'd1);

		if (complete && eff_phase == shp_pkg::EL_FIELD_PIC) field_nx = acc_nx[0];
		nxt = shp_pkg::next_code(eff_phase, acc_nx[0], cfg, eff_field, eff_idr);

		if (err) begin
			done_nx  = 1'b1;
			phase_nx = shp_pkg::EL_DONE;
		end else if (complete) begin
			if (nxt == shp_pkg::EL_DONE) begin
				done_nx  = 1'b1;
				phase_nx = shp_pkg::EL_DONE;
			end else begin
				phase_nx = nxt;
				zc_nx    = 6'd0;
				acc_nx   = '0;
				m_nx     = 3'd0;
				left_nx  = (shp_pkg::kind_of(nxt) == shp_pkg::KIND_FIX) ?
				           {1'b0, shp_pkg::fixed_width(nxt, cfg)} : 6'd0;
			end
		end
	end

	assign tot_ext = HW'(total_nx);
	assign push    = step && (complete || err);

	always_comb begin
		res.element  = eff_phase;
		res.value    = err ? '0 : v;
		res.last     = err || (nxt == shp_pkg::EL_DONE);
		res.hdr_bits = (tot_ext > HW'(1023)) ? shp_pkg::HB_W'(1023) : tot_ext[shp_pkg::HB_W-1:0];
		res.err      = err;
	end

	// leftover bits of a byte are dropped once the header ends
	assign fin   = run && (eff_done || (step && (bit_idx_q == 3'd0 || done_nx)));
	assign q_pop = (!run || fin) && q_valid;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			shp_pkg::ENG_IDLE: begin
				if (q_valid) state_nx = shp_pkg::ENG_RUN;
			end
			shp_pkg::ENG_RUN: begin
				if (fin && !q_valid) state_nx = shp_pkg::ENG_IDLE;
			end
			default: state_nx = shp_pkg::ENG_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= shp_pkg::ENG_IDLE;
		else state_q <= state_nx;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			byte_q     <= q_word.data;
			byte_idr_q <= q_word.idr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= 1'b0;
			bit_idx_q <= 3'd7;
			phase_q   <= shp_pkg::EL_FIRST_MB;
			zc_q      <= 6'd0;
			acc_q     <= '0;
			left_q    <= 6'd0;
			m_q       <= 3'd0;
			total_q   <= '0;
			field_q   <= 1'b0;
			idr_q     <= 1'b0;
			done_q    <= 1'b1;
		end else begin
			if (step) begin
				phase_q <= phase_nx;
				zc_q    <= zc_nx;
				acc_q   <= acc_nx;
				left_q  <= left_nx;
				m_q     <= m_nx;
				total_q <= total_nx;
				field_q <= field_nx;
				idr_q   <= eff_idr;
				done_q  <= done_nx;
			end
			if (q_pop) begin
				first_q   <= q_word.first;
				bit_idx_q <= 3'd7;
			end else if (step) begin
				first_q   <= 1'b0;
				bit_idx_q <= bit_idx_q - 3'd1;
			end
		end
	end

`ifndef SYNTH
	a_push_space: assert property (@(posedge clk) disable iff (!arst_n) push |-> space)
		else $error("result pushed into a full output queue");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n) push && res.err |-> res.last)
		else $error("code error word not marked last");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n) push && res.last |=> done_q)
		else $error("parser still active after last element");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty input queue");
`endif

endmodule

[rtl/core/h264_slice_header_parser.sv]
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    data_byte, first_byte, idr_slice
// out       output     out_valid / out_ready  element, value, last, header_bits, code_error
// apb cfg   input      psel, penable, pwrite  paddr, pwdata, prdata (pready tied high)
//
// A header byte goes through the bit engine one bit per cycle while the result queue
// has space; bytes outside a header and bits left after the last element are dropped.
// A two-word input queue takes bytes while the engine works; a two-word result queue
// holds finished elements, and the engine stalls on a bit only while that queue is full.
// arst_n clears all control state at once; no clearing pass is needed.
module h264_slice_header_parser #(
	parameter int MAX_HEADER_BITS = 1023
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [shp_pkg::CFG_AW-1:0]       paddr,
	input  logic [shp_pkg::DATA_W-1:0]       pwdata,
	output logic [shp_pkg::DATA_W-1:0]       prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       data_byte,
	input  logic                             first_byte,
	input  logic                             idr_slice,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [3:0]                       element,
	output logic signed [shp_pkg::VAL_W-1:0] value,
	output logic                             last,
	output logic [shp_pkg::HB_W-1:0]         header_bits,
	output logic                             code_error
);

	logic       sep_planes_q;
	logic [4:0] frame_num_w_q;
	logic       mbs_only_q;
	logic [1:0] poc_type_q;
	logic [4:0] poc_lsb_w_q;
	logic       bottom_poc_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	shp_pkg::cfg_t     cfg;
	shp_pkg::in_word_t in_word, q_word;
	shp_pkg::result_t  push_res, out_res;
	logic              q_valid, q_pop, space, push;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_planes_q  <= 1'b0;
			frame_num_w_q <= 5'd4;
			mbs_only_q    <= 1'b1;
			poc_type_q    <= 2'd0;
			poc_lsb_w_q   <= 5'd4;
			bottom_poc_q  <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				shp_pkg::REG_SEP_PLANES:  sep_planes_q  <= pwdata[0];
				shp_pkg::REG_FRAME_NUM_W: frame_num_w_q <= pwdata[4:0];
				shp_pkg::REG_MBS_ONLY:    mbs_only_q    <= pwdata[0];
				shp_pkg::REG_POC_TYPE:    poc_type_q    <= pwdata[1:0];
				shp_pkg::REG_POC_LSB_W:   poc_lsb_w_q   <= pwdata[4:0];
				shp_pkg::REG_BOTTOM_POC:  bottom_poc_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			shp_pkg::REG_SEP_PLANES:  prdata = shp_pkg::DATA_W'(sep_planes_q);
			shp_pkg::REG_FRAME_NUM_W: prdata = shp_pkg::DATA_W'(frame_num_w_q);
			shp_pkg::REG_MBS_ONLY:    prdata = shp_pkg::DATA_W'(mbs_only_q);
			shp_pkg::REG_POC_TYPE:    prdata = shp_pkg::DATA_W'(poc_type_q);
			shp_pkg::REG_POC_LSB_W:   prdata = shp_pkg::DATA_W'(poc_lsb_w_q);
			shp_pkg::REG_BOTTOM_POC:  prdata = shp_pkg::DATA_W'(bottom_poc_q);
			default:                  prdata = '0;
		endcase
	end

	always_comb begin
		cfg.sep_planes  = sep_planes_q;
		cfg.frame_num_w = shp_pkg::clamp_width(frame_num_w_q);
		cfg.mbs_only    = mbs_only_q;
		cfg.poc_type    = poc_type_q;
		cfg.poc_lsb_w   = shp_pkg::clamp_width(poc_lsb_w_q);
		cfg.bottom_poc  = bottom_poc_q;
	end

	always_comb begin
		in_word.data  = data_byte;
		in_word.first = first_byte;
		in_word.idr   = idr_slice;
	end

	shp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.q_valid  (q_valid),
		.q_word   (q_word),
		.q_pop    (q_pop)
	);

	shp_engine #(
		.MAX_HEADER_BITS (MAX_HEADER_BITS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (q_valid),
		.q_word  (q_word),
		.q_pop   (q_pop),
		.space   (space),
		.push    (push),
		.res     (push_res)
	);

	shp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (push_res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign element     = out_res.element;
	assign value       = out_res.value;
	assign last        = out_res.last;
	assign header_bits = out_res.hdr_bits;
	assign code_error  = out_res.err;

endmodule

[test/h264_slice_header_parser_check.sv]
`timescale 1ns / 100ps

module h264_slice_header_parser_check
	import shp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic                    pready,
	input  logic [CFG_AW-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [7:0]              data_byte,
	input  logic                    first_byte,
	input  logic                    idr_slice,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [3:0]              element,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    last,
	input  logic [HB_W-1:0]         header_bits,
	input  logic                    code_error,
	output int                      fails,
	output int                      pending,
	output int                      compared
);

	localparam int HDR_BITS_MAX = 1023;

	cfg_t        regs;
	elem_t       cur;
	int          zeros;
	logic [32:0] acc;
	int          remaining;
	int          bit_count;
	logic        field_pic;
	logic        idr_pic;
	logic        idle;
	result_t     elem_q[$];
	result_t     head;
	int          fail_cnt;
	int          seen;

	function automatic int clamped(input logic [4:0] w);
		if (w < WIDTH_MIN) return int'(WIDTH_MIN);
		if (w > WIDTH_MAX) return int'(WIDTH_MAX);
		return int'(w);
	endfunction

	function automatic logic is_se(input elem_t e);
		return e == EL_DELTA_POC_BOT || e == EL_QP_DELTA;
	endfunction

	function automatic logic is_fixed(input elem_t e);
		return !(is_se(e) || e == EL_FIRST_MB || e == EL_SLICE_TYPE || e == EL_PPS_ID ||
			e == EL_IDR_PIC_ID);
	endfunction

	function automatic int field_width(input elem_t e);
		case (e)
			EL_COLOUR_PLANE: return 2;
			EL_FRAME_NUM:    return clamped(regs.frame_num_w);
			EL_POC_LSB:      return clamped(regs.poc_lsb_w);
			default:         return 1;
		endcase
	endfunction

	// element following e, given the current flags and register values
	function automatic elem_t follow(input elem_t e, input logic flag);
		elem_t past_poc, past_idr, past_field, n;
		past_poc   = idr_pic ? EL_NO_OUTPUT : EL_QP_DELTA;
		past_idr   = (regs.poc_type == 2'd0) ? EL_POC_LSB : past_poc;
		past_field = idr_pic ? EL_IDR_PIC_ID : past_idr;
		case (e)
			EL_FIRST_MB:      n = EL_SLICE_TYPE;
			EL_SLICE_TYPE:    n = EL_PPS_ID;
			EL_PPS_ID:        n = regs.sep_planes ? EL_COLOUR_PLANE : EL_FRAME_NUM;
			EL_COLOUR_PLANE:  n = EL_FRAME_NUM;
			EL_FRAME_NUM:     n = regs.mbs_only ? past_field : EL_FIELD_PIC;
			EL_FIELD_PIC:     n = flag ? EL_BOTTOM_FIELD : past_field;
			EL_BOTTOM_FIELD:  n = past_field;
			EL_IDR_PIC_ID:    n = past_idr;
			EL_POC_LSB:       n = (!field_pic && regs.bottom_poc) ? EL_DELTA_POC_BOT : past_poc;
			EL_DELTA_POC_BOT: n = past_poc;
			EL_NO_OUTPUT:     n = EL_LONG_TERM;
			EL_LONG_TERM:     n = EL_QP_DELTA;
			default:          n = EL_DONE;
		endcase
		return n;
	endfunction

	task automatic start_element(input elem_t e);
		cur = e;
		zeros = 0;
		acc = '0;
		remaining = is_fixed(e) ? field_width(e) : 0;
	endtask

	task automatic expect_elem(input elem_t e, input logic [32:0] v, input logic fin,
		input logic err);
		elem_q.push_back('{element: e, value: v, last: fin, hdr_bits: bit_count[HB_W-1:0],
			err: err});
	endtask

	task automatic take_write(input logic [2:0] idx, input logic [DATA_W-1:0] d);
		case (idx)
			REG_SEP_PLANES:  regs.sep_planes = d[0];
			REG_FRAME_NUM_W: regs.frame_num_w = d[4:0];
			REG_MBS_ONLY:    regs.mbs_only = d[0];
			REG_POC_TYPE:    regs.poc_type = d[1:0];
			REG_POC_LSB_W:   regs.poc_lsb_w = d[4:0];
			REG_BOTTOM_POC:  regs.bottom_poc = d[0];
			default: ;
		endcase
	endtask

	// walk one payload word bit by bit, msb first
	task automatic decode_byte(input logic [7:0] b, input logic first, input logic idr);
		int i;
		logic bitv, complete;
		logic [63:0] v;
		elem_t nxt;
		if (first) begin
			idr_pic = idr;
			field_pic = 1'b0;
			bit_count = 0;
			idle = 1'b0;
			start_element(EL_FIRST_MB);
		end
		for (i = 7; i >= 0; i--) begin
			if (!idle) begin
				bitv = b[i];
				complete = 1'b0;
				v = '0;
				if (bit_count < HDR_BITS_MAX) bit_count++;
				if (is_fixed(cur)) begin
					acc = {acc[31:0], bitv};
					if (remaining > 0) remaining--;
					if (remaining == 0) begin
						complete = 1'b1;
						v = 64'(acc);
					end
				end else if (remaining > 0) begin
					acc = {acc[31:0], bitv};
					remaining--;
					if (remaining == 0) begin
						complete = 1'b1;
						v = (64'd1 << zeros) - 64'd1 + 64'(acc);
					end
				end else if (!bitv) begin
					zeros++;
					if (zeros > 31) begin
						expect_elem(cur, '0, 1'b1, 1'b1);
						idle = 1'b1;
					end
				end else if (zeros == 0) begin
					complete = 1'b1;
				end else begin
					remaining = zeros;
					acc = '0;
				end
				if (complete) begin
					if (is_se(cur)) v = v[0] ? (v + 64'd1) >> 1 : 64'd0 - (v >> 1);
					if (cur == EL_SLICE_TYPE) v = v % 64'd5;
					if (cur == EL_FIELD_PIC) field_pic = v[0];
					nxt = follow(cur, v[0]);
					expect_elem(cur, v[32:0], nxt == EL_DONE, 1'b0);
					if (nxt == EL_DONE) idle = 1'b1;
					else start_element(nxt);
				end
			end
		end
	endtask

	task automatic mismatch(input string fname, input longint want, input longint got);
		fail_cnt++;
		$error("%s: expected %0d, got %0d", fname, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{sep_planes: 1'b0, frame_num_w: 5'd4, mbs_only: 1'b1, poc_type: 2'd0,
				poc_lsb_w: 5'd4, bottom_poc: 1'b0};
			cur = EL_FIRST_MB;
			zeros = 0;
			acc = '0;
			remaining = 0;
			bit_count = 0;
			field_pic = 1'b0;
			idr_pic = 1'b0;
			idle = 1'b1;
			elem_q.delete();
			fail_cnt = 0;
			seen = 0;
		end else begin
			if (psel && penable && pwrite && pready) take_write(paddr[CFG_AW-1:2], pwdata);
			if (in_valid && in_ready) decode_byte(data_byte, first_byte, idr_slice);
			if (out_valid && out_ready) begin
				if (elem_q.size() == 0) begin
					fail_cnt++;
					$error("element %0d value %0d with nothing expected", element, value);
				end else begin
					head = elem_q.pop_front();
					seen++;
					if (element !== head.element) mismatch("element", head.element, element);
					if (value !== head.value)
						mismatch("value", $signed(head.value), $signed(value));
					if (last !== head.last) mismatch("last", head.last, last);
					if (header_bits !== head.hdr_bits)
						mismatch("header_bits", head.hdr_bits, header_bits);
					if (code_error !== head.err) mismatch("code_error", head.err, code_error);
				end
			end
		end
		pending <= elem_q.size();
		fails <= fail_cnt;
		compared <= seen;
	end

endmodule

[test/h264_slice_header_parser_test.sv]
`timescale 1ns / 100ps

module h264_slice_header_parser_test;
	import shp_pkg::*;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [CFG_AW-1:0]       paddr = '0;
	logic [DATA_W-1:0]       pwdata = '0;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [7:0]              data_byte = '0;
	logic                    first_byte = 1'b0;
	logic                    idr_slice = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [3:0]              element;
	logic signed [VAL_W-1:0] value;
	logic                    last;
	logic [HB_W-1:0]         header_bits;
	logic                    code_error;
	int                      fails;
	int                      pending;
	int                      compared;

	// stimulus state
	cfg_t setting;
	bit   hdr_bits[$];
	int   codes_done;
	int   bad_at;
	int   force_z = -1;
	bit   stopped;
	bit   calm = 1'b0;
	int   items;
	int   headers;
	int   bad_headers;
	int   settings_used;

	h264_slice_header_parser dut (.*);

	h264_slice_header_parser_check chk (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	// result side: a random stall before each word
	initial begin
		int n;
		forever begin
			n = calm ? 0 : $urandom_range(0, 3);
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic int eff_width(input logic [4:0] w);
		if (w < WIDTH_MIN) return int'(WIDTH_MIN);
		if (w > WIDTH_MAX) return int'(WIDTH_MAX);
		return int'(w);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic first, input logic idr);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		first_byte <= first;
		idr_slice <= idr;
		do @(posedge clk); while (!in_ready);
		items++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	// junk above each register's width must be dropped
	task automatic apply(input cfg_t c);
		write_reg(REG_SEP_PLANES, {31'($urandom), c.sep_planes});
		write_reg(REG_FRAME_NUM_W, {27'($urandom), c.frame_num_w});
		write_reg(REG_MBS_ONLY, {31'($urandom), c.mbs_only});
		write_reg(REG_POC_TYPE, {30'($urandom), c.poc_type});
		write_reg(REG_POC_LSB_W, {27'($urandom), c.poc_lsb_w});
		write_reg(REG_BOTTOM_POC, {31'($urandom), c.bottom_poc});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		setting = c;
		settings_used++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic put_bits(input logic [31:0] v, input int w);
		int k;
		if (!stopped)
			for (k = w - 1; k >= 0; k--) hdr_bits.push_back(v[k]);
	endtask

	// Exp-Golomb code with a random prefix; bad_at picks the code that gets 32+ zeros
	task automatic put_code();
		int z, k, r;
		if (!stopped) begin
			if (codes_done == bad_at) begin
				repeat (32 + $urandom_range(0, 6)) hdr_bits.push_back(1'b0);
				stopped = 1'b1;
			end else begin
				r = $urandom_range(0, 19);
				if (force_z >= 0) z = force_z;
				else if (r < 14) z = $urandom_range(0, 2);
				else if (r < 18) z = $urandom_range(3, 10);
				else z = $urandom_range(11, 31);
				repeat (z) hdr_bits.push_back(1'b0);
				hdr_bits.push_back(1'b1);
				for (k = 0; k < z; k++)
					hdr_bits.push_back(force_z >= 0 ? 1'b1 : 1'($urandom_range(0, 1)));
				force_z = -1;
				codes_done++;
			end
		end
	endtask

	task automatic build(input bit idr);
		bit fp;
		fp = 1'b0;
		put_code();
		put_code();
		put_code();
		if (setting.sep_planes) put_bits($urandom, 2);
		put_bits($urandom, eff_width(setting.frame_num_w));
		if (!setting.mbs_only) begin
			fp = 1'($urandom_range(0, 1));
			put_bits(32'(fp), 1);
			if (fp) put_bits($urandom, 1);
		end
		if (idr) put_code();
		if (setting.poc_type == 2'd0) begin
			put_bits($urandom, eff_width(setting.poc_lsb_w));
			if (!fp && setting.bottom_poc) put_code();
		end
		if (idr) put_bits($urandom, 2);
		put_code();
	endtask

	// cut > 0 keeps at most that many bits, which can leave the header unfinished
	task automatic run_header(input bit idr, input int bad_code, input int cut);
		int n, k;
		logic [7:0] b;
		hdr_bits.delete();
		codes_done = 0;
		bad_at = bad_code;
		stopped = 1'b0;
		build(idr);
		if (cut > 0)
			while (hdr_bits.size() > cut) void'(hdr_bits.pop_back());
		while (hdr_bits.size() % 8 != 0) hdr_bits.push_back(1'($urandom_range(0, 1)));
		for (n = 0; n < hdr_bits.size(); n += 8) begin
			for (k = 0; k < 8; k++) b = {b[6:0], hdr_bits[n + k]};
			send_byte(b, n == 0, n == 0 ? idr : 1'($urandom_range(0, 1)));
		end
		headers++;
		if (bad_code >= 0) bad_headers++;
	endtask

	task automatic random_sequence();
		int r;
		bit idr;
		r = $urandom_range(0, 99);
		idr = 1'($urandom_range(0, 1));
		calm = ($urandom_range(0, 4) == 0);
		if (r < 65) begin
			run_header(idr, -1, 0);
			repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0, 1'($urandom));
		end else if (r < 78) begin
			run_header(idr, -1, $urandom_range(1, 40));
		end else if (r < 90) begin
			run_header(idr, $urandom_range(0, 3), 0);
		end else begin
			repeat ($urandom_range(1, 4))
				send_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'($urandom));
		end
	endtask

	initial begin
		int ph, target;
		cfg_t c;
		cfg_t presets [5];
		presets[0] = '{1'b1, 5'd16, 1'b0, 2'd0, 5'd16, 1'b1};
		presets[1] = '{1'b0, 5'd4, 1'b0, 2'd0, 5'd4, 1'b1};
		presets[2] = '{1'b1, 5'd0, 1'b1, 2'd3, 5'd31, 1'b1};
		presets[3] = '{1'b0, 5'd3, 1'b0, 2'd1, 5'd17, 1'b0};
		presets[4] = '{1'b1, 5'd16, 1'b1, 2'd2, 5'd4, 1'b0};
		setting = '{1'b0, 5'd4, 1'b1, 2'd0, 5'd4, 1'b0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset register values
		send_byte(8'hA5, 1'b0, 1'b1);   // nothing in progress, dropped
		run_header(1'b0, -1, 0);
		send_byte(8'hFF, 1'b0, 1'b0);   // after the last element, dropped
		force_z = 31;                   // largest ue value on first_mb
		run_header(1'b1, -1, 0);
		run_header(1'b0, 0, 0);         // overlong prefix on the first code
		run_header(1'b1, -1, 8);        // abandoned by the next first_byte
		run_header(1'b0, -1, 0);

		for (ph = 0; ph < 8; ph++) begin
			drain();
			if (ph < 5) begin
				c = presets[ph];
			end else begin
				c.sep_planes = 1'($urandom_range(0, 1));
				c.frame_num_w = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) :
					5'($urandom_range(4, 16));
				c.mbs_only = 1'($urandom_range(0, 1));
				c.poc_type = 2'($urandom_range(0, 3));
				c.poc_lsb_w = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) :
					5'($urandom_range(4, 16));
				c.bottom_poc = 1'($urandom_range(0, 1));
			end
			apply(c);
			target = items + 55;
			while (items < target) random_sequence();
		end

		calm = 1'b0;
		drain();
		$display("covered %0d payload bytes in %0d headers (%0d with an overlong prefix)",
			items, headers, bad_headers);
		$display("over %0d register settings; %0d decoded elements compared",
			settings_used + 1, compared);
		if (fails == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/shp_pkg.sv
rtl/core/shp_front.sv
rtl/core/shp_out_buf.sv
rtl/core/shp_engine.sv
rtl/core/h264_slice_header_parser.sv
test/h264_slice_header_parser_check.sv
test/h264_slice_header_parser_test.sv
